// File: rtl/core/hbdw_pkg.sv
// shared types, codes and reset values for the held-button dead-man watchdog
// used by held_button_deadman_watchdog; no dependencies

package hbdw_pkg;

    // event codes carried in the action field
    typedef enum logic [2:0] {
        ACT_BEGIN     = 3'd0,
        ACT_RELEASE   = 3'd1,
        ACT_TICK      = 3'd2,
        ACT_ABANDON   = 3'd3,
        ACT_HEARTBEAT = 3'd4,
        ACT_PUBLISH   = 3'd5
    } t_action;

    // session phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_HELD  = 2'd1,
        PH_ENDED = 2'd2
    } t_phase;

    // why a session ended
    typedef enum logic [2:0] {
        CAUSE_NONE     = 3'd0,
        CAUSE_CAP      = 3'd1,
        CAUSE_IDLE     = 3'd2,
        CAUSE_RELEASED = 3'd3,
        CAUSE_LOST     = 3'd4
    } t_cause;

    // tick or abandon result
    typedef enum logic [1:0] {
        OUT_NOTHING  = 2'd0,
        OUT_MOVED    = 2'd1,
        OUT_RELEASED = 2'd2
    } t_outcome;

    // configuration register indexes
    typedef enum logic [2:0] {
        CFG_IDLE_MIN     = 3'd0,
        CFG_IDLE_MAX     = 3'd1,
        CFG_IDLE_DEFAULT = 3'd2,
        CFG_CAP_MIN      = 3'd3,
        CFG_CAP_MAX      = 3'd4,
        CFG_CAP_DEFAULT  = 3'd5
    } t_cfg_idx;

    localparam int          CfgCount     = 6;
    localparam logic [31:0] RstIdleMin   = 32'd6;
    localparam logic [31:0] RstIdleMax   = 32'd600;
    localparam logic [31:0] RstIdleDflt  = 32'd60;
    localparam logic [31:0] RstCapMin    = 32'd60;
    localparam logic [31:0] RstCapMax    = 32'd3600;
    localparam logic [31:0] RstCapDflt   = 32'd600;

    // one input transaction
    typedef struct packed {
        logic [2:0]         action;
        logic [31:0]        session;
        logic signed [31:0] pos_h;
        logic signed [31:0] pos_v;
        logic [31:0]        now_ticks;
        logic [31:0]        idle_request;
        logic [31:0]        cap_request;
        logic               has_destination;
        logic signed [31:0] dest_h;
        logic signed [31:0] dest_v;
    } t_in_item;

    // one result transaction
    typedef struct packed {
        logic               accepted;
        logic [1:0]         outcome;
        logic [2:0]         end_cause;
        logic [31:0]        end_stamp;
        logic signed [31:0] cursor_h;
        logic signed [31:0] cursor_v;
        logic               button_held;
        logic               mouseup_owed;
    } t_out_item;

    // zero takes the default, then the min test, then the max test
    function automatic logic [31:0] clamp_req(
        input logic [31:0] req,
        input logic [31:0] lo,
        input logic [31:0] hi,
        input logic [31:0] dflt
    );
        logic [31:0] res;
        if (req == 32'd0) begin
            res = dflt;
        end else if (req < lo) begin
            res = lo;
        end else if (req > hi) begin
            res = hi;
        end else begin
            res = req;
        end
        return res;
    endfunction

endpackage

// File: rtl/core/held_button_deadman_watchdog.sv
// top level of the held-button dead-man watchdog: input register, event logic,
// session state and result register; depends on hbdw_pkg
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+--------------------------
//  in       | input     | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//  out      | output    | o_out_valid / i_out_ready | o_out_data (t_out_item)
//  cfg      | input     | i_cfg_we (no wait)        | i_cfg_index, i_cfg_data
//
// each event passes through the input register and then the result
// register; one event per cycle is sustained while the output side takes.
// the event logic is a few 32-bit subtracts and compares on session state.
// reset is synchronous, active low; config returns to its defaults.
// when the result register is full and not taken, the input register holds
// and o_in_ready drops only once both stages are full.

module held_button_deadman_watchdog (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  hbdw_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output hbdw_pkg::t_out_item o_out_data,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);

    // pipeline control
    logic                r_in_vld;
    hbdw_pkg::t_in_item  r_in;
    logic                r_out_vld;
    hbdw_pkg::t_out_item r_out;
    hbdw_pkg::t_out_item n_out;
    logic                advance;

    // configuration
    logic [31:0] r_idle_min, r_idle_max, r_idle_dflt;
    logic [31:0] r_cap_min, r_cap_max, r_cap_dflt;

    // session state
    hbdw_pkg::t_phase   r_phase, n_phase;
    logic [31:0]        r_session, n_session;
    logic signed [31:0] r_want_h, n_want_h, r_want_v, n_want_v;
    logic [31:0]        r_want_count, n_want_count;
    logic [31:0]        r_moves_done, n_moves_done;
    logic [31:0]        r_pend_rel, n_pend_rel;
    logic [31:0]        r_hb_stamp, n_hb_stamp;
    logic [31:0]        r_begin_stamp, n_begin_stamp;
    logic [31:0]        r_move_stamp, n_move_stamp;
    logic [31:0]        r_idle_limit, n_idle_limit;
    logic [31:0]        r_cap_limit, n_cap_limit;
    logic signed [31:0] r_at_h, n_at_h, r_at_v, n_at_v;
    logic [2:0]         r_end_cause, n_end_cause;
    logic [31:0]        r_end_stamp, n_end_stamp;
    logic               r_button, n_button;
    logic               r_mouseup, n_mouseup;

    // event decode
    logic        held;
    logic        begin_ok;
    logic        end_sess;
    logic        acc;
    logic [1:0]  res;
    logic [31:0] cap_age;
    logic [31:0] hb_gap;
    logic [31:0] idle_ref;
    logic [31:0] idle_age;
    logic        cap_hit;
    logic        idle_hit;

    // handshake: a stage moves on when the result register is free or drained
    assign advance     = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || advance;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle_min  <= hbdw_pkg::RstIdleMin;
            r_idle_max  <= hbdw_pkg::RstIdleMax;
            r_idle_dflt <= hbdw_pkg::RstIdleDflt;
            r_cap_min   <= hbdw_pkg::RstCapMin;
            r_cap_max   <= hbdw_pkg::RstCapMax;
            r_cap_dflt  <= hbdw_pkg::RstCapDflt;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hbdw_pkg::CFG_IDLE_MIN:     r_idle_min  <= i_cfg_data;
                hbdw_pkg::CFG_IDLE_MAX:     r_idle_max  <= i_cfg_data;
                hbdw_pkg::CFG_IDLE_DEFAULT: r_idle_dflt <= i_cfg_data;
                hbdw_pkg::CFG_CAP_MIN:      r_cap_min   <= i_cfg_data;
                hbdw_pkg::CFG_CAP_MAX:      r_cap_max   <= i_cfg_data;
                hbdw_pkg::CFG_CAP_DEFAULT:  r_cap_dflt  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // wrap-safe ages: cap from begin, idle from the newer of move and heartbeat
    assign held     = (r_phase == hbdw_pkg::PH_HELD);
    assign cap_age  = r_in.now_ticks - r_begin_stamp;
    assign cap_hit  = (cap_age >= r_cap_limit);
    assign hb_gap   = r_hb_stamp - r_move_stamp;
    assign idle_ref = hb_gap[31] ? r_move_stamp : r_hb_stamp;
    assign idle_age = r_in.now_ticks - idle_ref;
    assign idle_hit = (idle_age >= r_idle_limit);

    // event processing for everything but the phase
    always_comb begin
        n_session     = r_session;
        n_want_h      = r_want_h;
        n_want_v      = r_want_v;
        n_want_count  = r_want_count;
        n_moves_done  = r_moves_done;
        n_pend_rel    = r_pend_rel;
        n_hb_stamp    = r_hb_stamp;
        n_begin_stamp = r_begin_stamp;
        n_move_stamp  = r_move_stamp;
        n_idle_limit  = r_idle_limit;
        n_cap_limit   = r_cap_limit;
        n_at_h        = r_at_h;
        n_at_v        = r_at_v;
        n_end_cause   = r_end_cause;
        n_end_stamp   = r_end_stamp;
        n_button      = r_button;
        n_mouseup     = r_mouseup;
        begin_ok      = 1'b0;
        end_sess      = 1'b0;
        acc           = 1'b0;
        res           = hbdw_pkg::OUT_NOTHING;

        unique case (r_in.action)
            hbdw_pkg::ACT_BEGIN: begin
                if (r_in.session != 32'd0 && !held) begin
                    begin_ok      = 1'b1;
                    acc           = 1'b1;
                    n_session     = r_in.session;
                    n_want_h      = r_in.has_destination ? r_in.dest_h : r_in.pos_h;
                    n_want_v      = r_in.has_destination ? r_in.dest_v : r_in.pos_v;
                    n_want_count  = {31'd0, r_in.has_destination};
                    n_pend_rel    = 32'd0;
                    n_hb_stamp    = r_in.now_ticks;
                    n_at_h        = r_in.pos_h;
                    n_at_v        = r_in.pos_v;
                    n_begin_stamp = r_in.now_ticks;
                    n_move_stamp  = r_in.now_ticks;
                    n_end_cause   = hbdw_pkg::CAUSE_NONE;
                    n_end_stamp   = 32'd0;
                    n_idle_limit  = hbdw_pkg::clamp_req(r_in.idle_request, r_idle_min,
                                                        r_idle_max, r_idle_dflt);
                    n_cap_limit   = hbdw_pkg::clamp_req(r_in.cap_request, r_cap_min,
                                                        r_cap_max, r_cap_dflt);
                    n_moves_done  = 32'd0;
                    n_mouseup     = 1'b0;
                    n_button      = 1'b1;
                end
            end
            hbdw_pkg::ACT_RELEASE: begin
                if (r_in.session != 32'd0 && held && r_session == r_in.session) begin
                    n_pend_rel = r_in.session;
                    acc        = 1'b1;
                end
            end
            hbdw_pkg::ACT_TICK: begin
                if (held) begin
                    if (cap_hit) begin
                        end_sess    = 1'b1;
                        n_end_cause = hbdw_pkg::CAUSE_CAP;
                    end else if (idle_hit) begin
                        end_sess    = 1'b1;
                        n_end_cause = hbdw_pkg::CAUSE_IDLE;
                    end else if (r_pend_rel != 32'd0 && r_pend_rel == r_session) begin
                        end_sess    = 1'b1;
                        n_end_cause = hbdw_pkg::CAUSE_RELEASED;
                    end else begin
                        // stale release dropped, then consume a new destination
                        n_pend_rel = 32'd0;
                        if (r_want_count != 32'd0 && r_want_count != r_moves_done) begin
                            n_at_h       = r_want_h;
                            n_at_v       = r_want_v;
                            n_moves_done = r_want_count;
                            n_move_stamp = r_in.now_ticks;
                            res          = hbdw_pkg::OUT_MOVED;
                        end
                    end
                end
            end
            hbdw_pkg::ACT_ABANDON: begin
                if (held) begin
                    end_sess    = 1'b1;
                    n_end_cause = hbdw_pkg::CAUSE_LOST;
                end
            end
            hbdw_pkg::ACT_HEARTBEAT: begin
                n_hb_stamp = r_in.now_ticks;
            end
            hbdw_pkg::ACT_PUBLISH: begin
                n_want_h     = r_in.dest_h;
                n_want_v     = r_in.dest_v;
                n_want_count = r_want_count + 32'd1;
            end
            default: ;
        endcase

        // session end lifts the button and owes a mouse-up
        if (end_sess) begin
            n_end_stamp = r_in.now_ticks;
            n_pend_rel  = 32'd0;
            n_button    = 1'b0;
            n_mouseup   = 1'b1;
            res         = hbdw_pkg::OUT_RELEASED;
        end
    end

    // phase next state
    always_comb begin
        n_phase = r_phase;
        if (begin_ok) begin
            n_phase = hbdw_pkg::PH_HELD;
        end else if (end_sess) begin
            n_phase = hbdw_pkg::PH_ENDED;
        end
    end

    // result transaction from the updated state
    always_comb begin
        n_out.accepted     = acc;
        n_out.outcome      = res;
        n_out.end_cause    = n_end_cause;
        n_out.end_stamp    = n_end_stamp;
        n_out.cursor_h     = n_at_h;
        n_out.cursor_v     = n_at_v;
        n_out.button_held  = n_button;
        n_out.mouseup_owed = n_mouseup;
    end

    // session state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= hbdw_pkg::PH_IDLE;
            r_session     <= 32'd0;
            r_want_h      <= 32'sd0;
            r_want_v      <= 32'sd0;
            r_want_count  <= 32'd0;
            r_moves_done  <= 32'd0;
            r_pend_rel    <= 32'd0;
            r_hb_stamp    <= 32'd0;
            r_begin_stamp <= 32'd0;
            r_move_stamp  <= 32'd0;
            r_idle_limit  <= 32'd0;
            r_cap_limit   <= 32'd0;
            r_at_h        <= 32'sd0;
            r_at_v        <= 32'sd0;
            r_end_cause   <= hbdw_pkg::CAUSE_NONE;
            r_end_stamp   <= 32'd0;
            r_button      <= 1'b0;
            r_mouseup     <= 1'b0;
        end else if (advance) begin
            r_phase       <= n_phase;
            r_session     <= n_session;
            r_want_h      <= n_want_h;
            r_want_v      <= n_want_v;
            r_want_count  <= n_want_count;
            r_moves_done  <= n_moves_done;
            r_pend_rel    <= n_pend_rel;
            r_hb_stamp    <= n_hb_stamp;
            r_begin_stamp <= n_begin_stamp;
            r_move_stamp  <= n_move_stamp;
            r_idle_limit  <= n_idle_limit;
            r_cap_limit   <= n_cap_limit;
            r_at_h        <= n_at_h;
            r_at_v        <= n_at_v;
            r_end_cause   <= n_end_cause;
            r_end_stamp   <= n_end_stamp;
            r_button      <= n_button;
            r_mouseup     <= n_mouseup;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule
